// ----- hdl/thermal_plant_model_step_macros.svh -----
// ----------------------------------------------------------------------------
// Thermal plant model step: assertion macros
// Shared concurrent assertion forms for the block's modules.
// ----------------------------------------------------------------------------
`ifndef THERMAL_PLANT_MODEL_STEP_MACROS_SVH
`define THERMAL_PLANT_MODEL_STEP_MACROS_SVH

`ifndef ASSERT_OFF
`define TPMS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define TPMS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TPMS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define TPMS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/tpms_pkg.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: package
// Types, fixed-point constants, command codes and the CORDIC angle table.
// ----------------------------------------------------------------------------
package tpms_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int COEF_W    = 16;
   localparam int ACC_W     = 64;
   localparam int ANG_W     = 48;
   localparam int CORDIC_W  = 34;
   localparam int SINE_W    = 18;
   localparam int MUL_W     = 33;
   localparam int SQ_W      = 47;
   localparam int CSR_IDX_W = 3;

   typedef logic signed [ANG_W-1:0]    ang_type;
   typedef logic signed [CORDIC_W-1:0] cordic_type;

   localparam ang_type    ANG_PI      = 48'sd3373259426;
   localparam ang_type    ANG_TWO_PI  = 48'sd6746518852;
   localparam ang_type    ANG_HALF_PI = 48'sd1686629713;
   localparam cordic_type GAIN_INV    = 34'sd652032874;
   localparam logic [3:0] REDUCE_TOP  = 4'd13;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd8192;
   localparam logic signed [ACC_W-1:0] SAT_MAX    = 64'sd2147483647;
   localparam logic signed [ACC_W-1:0] SAT_MIN    = -64'sd2147483648;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LIN_A = 3'd0,
      REG_LIN_B = 3'd1,
      REG_NL_A  = 3'd2,
      REG_NL_B  = 3'd3,
      REG_NL_C  = 3'd4,
      REG_NL_D  = 3'd5
   } csr_idx_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_LA, OP_LB, OP_NA, OP_NC, OP_SQ, OP_BL, OP_BH, OP_ND
   } mac_op_type;

   localparam logic [3:0] STEP_NC = 4'd3;
   localparam logic [3:0] STEP_ND = 4'd8;

   typedef enum logic [1:0] {CT_IDLE, CT_RUN, CT_DRAIN, CT_FINISH} ctrl_state_type;

   typedef enum logic [2:0] {SN_IDLE, SN_REDUCE, SN_FOLD, SN_ROT, SN_DONE} sine_state_type;

   typedef struct packed {
      logic       load;
      logic       sine_start;
      mac_op_type op;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic first_done;
      logic sine_done;
   } status_type;

   function automatic cordic_type atan_at(input logic [4:0] idx);
      cordic_type v;
      case (idx)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         5'd24: v = 34'sd64;
         5'd25: v = 34'sd32;
         5'd26: v = 34'sd16;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/tpms_req_if.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: request channel
// Valid/ready channel carrying one control sample per beat.
// ----------------------------------------------------------------------------
interface tpms_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [tpms_pkg::SAMPLE_W-1:0] u_in;
   logic                                restart;

   modport source(output valid, u_in, restart, input ready);
   modport sink(input valid, u_in, restart, output ready);
endinterface

// ----- hdl/tpms_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: response channel
// Valid/ready channel carrying both model outputs per beat.
// ----------------------------------------------------------------------------
interface tpms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tpms_pkg::SAMPLE_W-1:0] y_linear;
   logic signed [tpms_pkg::SAMPLE_W-1:0] y_nonlinear;
   logic                                saturated;

   modport source(output valid, y_linear, y_nonlinear, saturated, input ready);
   modport sink(input valid, y_linear, y_nonlinear, saturated, output ready);
endinterface

// ----- hdl/tpms_sine.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: sine unit
// Range reduction by restoring subtraction, then iterative CORDIC rotation.
// ----------------------------------------------------------------------------
module tpms_sine #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [tpms_pkg::SAMPLE_W-1:0] angle,
   output logic signed [tpms_pkg::SINE_W-1:0]   sine,
   output logic                                 done
);

   localparam int IW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
   localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_ITERATIONS - 1);

   tpms_pkg::sine_state_type state_ff, state_in;
   logic [3:0]               k_ff, k_in;
   logic [IW-1:0]            i_ff, i_in;
   logic                     done_ff, done_in;
   tpms_pkg::ang_type        t_ff, t_in;
   tpms_pkg::cordic_type     x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [tpms_pkg::SINE_W-1:0] sine_ff, sine_in;

   tpms_pkg::ang_type    scaled, modulus, r_wrap, r_fold;
   tpms_pkg::cordic_type dx, dy, atan_v, y_round;

   always_comb begin
      scaled  = tpms_pkg::ANG_W'(angle) <<< 14;
      modulus = tpms_pkg::ANG_TWO_PI <<< k_ff;
      r_wrap  = (t_ff > tpms_pkg::ANG_PI) ? t_ff - tpms_pkg::ANG_TWO_PI : t_ff;
      if (r_wrap > tpms_pkg::ANG_HALF_PI) begin
         r_fold = tpms_pkg::ANG_PI - r_wrap;
      end else if (r_wrap < -tpms_pkg::ANG_HALF_PI) begin
         r_fold = -tpms_pkg::ANG_PI - r_wrap;
      end else begin
         r_fold = r_wrap;
      end
      dx      = y_ff >>> i_ff;
      dy      = x_ff >>> i_ff;
      atan_v  = tpms_pkg::atan_at(5'(i_ff));
      y_round = (y_ff + 34'sd32768) >>> 16;
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      done_in  = done_ff;
      t_in     = t_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      sine_in  = sine_ff;
      if (start) begin
         // shift negative angles up so the restoring pass sees a positive value
         t_in     = (angle < 0) ? scaled + (tpms_pkg::ANG_TWO_PI <<< 13) : scaled;
         k_in     = tpms_pkg::REDUCE_TOP;
         done_in  = 1'b0;
         state_in = tpms_pkg::SN_REDUCE;
      end else begin
         case (state_ff)
            tpms_pkg::SN_IDLE: begin
            end
            tpms_pkg::SN_REDUCE: begin
               if (t_ff >= modulus) begin
                  t_in = t_ff - modulus;
               end
               if (k_ff == 4'd0) begin
                  state_in = tpms_pkg::SN_FOLD;
               end else begin
                  k_in = k_ff - 4'd1;
               end
            end
            tpms_pkg::SN_FOLD: begin
               z_in     = tpms_pkg::CORDIC_W'(r_fold);
               x_in     = tpms_pkg::GAIN_INV;
               y_in     = '0;
               i_in     = '0;
               state_in = tpms_pkg::SN_ROT;
            end
            tpms_pkg::SN_ROT: begin
               if (z_ff >= 0) begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
                  z_in = z_ff - atan_v;
               end else begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
                  z_in = z_ff + atan_v;
               end
               if (i_ff == LAST_ITER) begin
                  state_in = tpms_pkg::SN_DONE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
            tpms_pkg::SN_DONE: begin
               sine_in  = tpms_pkg::SINE_W'(y_round);
               done_in  = 1'b1;
               state_in = tpms_pkg::SN_IDLE;
            end
            default: begin
               state_in = tpms_pkg::SN_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpms_pkg::SN_IDLE;
         done_ff  <= 1'b0;
         k_ff     <= '0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
      end
      t_ff    <= t_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;
   assign done = done_ff;

endmodule

// ----- hdl/tpms_datapath.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: datapath
// Coefficient registers, model state, shared multiplier, accumulators,
// sine unit and the rounding/saturation output register.
// ----------------------------------------------------------------------------
module tpms_datapath #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tpms_pkg::cmd_type                     cmd,
   output tpms_pkg::status_type                  status,
   input  logic                                  csr_we,
   input  logic [tpms_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tpms_pkg::COEF_W-1:0]           csr_data,
   input  logic signed [tpms_pkg::SAMPLE_W-1:0]  u_in,
   input  logic                                  restart,
   output logic signed [tpms_pkg::SAMPLE_W-1:0]  y_linear,
   output logic signed [tpms_pkg::SAMPLE_W-1:0]  y_nonlinear,
   output logic                                  saturated
);

   localparam int PROD_W = 2 * tpms_pkg::MUL_W;

   logic signed [tpms_pkg::COEF_W-1:0] lin_a_ff, lin_b_ff, nl_a_ff, nl_b_ff, nl_c_ff, nl_d_ff;
   logic signed [tpms_pkg::SAMPLE_W-1:0] y_lin_last_ff, y_nl_last_ff, y_nl_before_ff;
   logic signed [tpms_pkg::SAMPLE_W-1:0] u_last_ff, u_ff;
   logic                                 first_done_ff;
   logic [tpms_pkg::SQ_W-1:0]            sq_ff;
   logic signed [PROD_W-1:0]             prod_ff;
   tpms_pkg::mac_op_type                 op_ff;
   logic signed [tpms_pkg::ACC_W-1:0]    acc_lin_ff, acc_nl_ff;
   logic signed [tpms_pkg::SAMPLE_W-1:0] y_lin_out_ff, y_nl_out_ff;
   logic                                 sat_out_ff;

   logic signed [tpms_pkg::MUL_W-1:0]    ma, mb;
   logic signed [tpms_pkg::ACC_W-1:0]    prod_acc;
   logic signed [tpms_pkg::SINE_W-1:0]   sine;
   logic                                 sine_done;
   logic [tpms_pkg::SAMPLE_W:0]          lin_res, nl_res;

   function automatic logic [tpms_pkg::SAMPLE_W:0] round_sat(
      input logic signed [tpms_pkg::ACC_W-1:0] acc
   );
      logic signed [tpms_pkg::ACC_W-1:0] r;
      r = (acc + tpms_pkg::ROUND_HALF) >>> 14;
      if (r > tpms_pkg::SAT_MAX) begin
         return {1'b1, tpms_pkg::SAMPLE_W'(tpms_pkg::SAT_MAX)};
      end else if (r < tpms_pkg::SAT_MIN) begin
         return {1'b1, tpms_pkg::SAMPLE_W'(tpms_pkg::SAT_MIN)};
      end
      return {1'b0, tpms_pkg::SAMPLE_W'(r)};
   endfunction

   tpms_sine #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_sine (
      .clock (clock),
      .reset (reset),
      .start (cmd.sine_start),
      .angle (u_last_ff),
      .sine  (sine),
      .done  (sine_done)
   );

   // operand select for the shared multiplier
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.op)
         tpms_pkg::OP_LA: begin ma = tpms_pkg::MUL_W'(lin_a_ff); mb = tpms_pkg::MUL_W'(y_lin_last_ff); end
         tpms_pkg::OP_LB: begin ma = tpms_pkg::MUL_W'(lin_b_ff); mb = tpms_pkg::MUL_W'(u_ff); end
         tpms_pkg::OP_NA: begin ma = tpms_pkg::MUL_W'(nl_a_ff);  mb = tpms_pkg::MUL_W'(y_nl_last_ff); end
         tpms_pkg::OP_NC: begin ma = tpms_pkg::MUL_W'(nl_c_ff);  mb = tpms_pkg::MUL_W'(u_ff); end
         tpms_pkg::OP_SQ: begin
            ma = tpms_pkg::MUL_W'(y_nl_before_ff);
            mb = tpms_pkg::MUL_W'(y_nl_before_ff);
         end
         tpms_pkg::OP_BL: begin
            ma = tpms_pkg::MUL_W'(nl_b_ff);
            mb = tpms_pkg::MUL_W'({1'b0, sq_ff[23:0]});
         end
         tpms_pkg::OP_BH: begin
            ma = tpms_pkg::MUL_W'(nl_b_ff);
            mb = tpms_pkg::MUL_W'({1'b0, sq_ff[tpms_pkg::SQ_W-1:24]});
         end
         tpms_pkg::OP_ND: begin ma = tpms_pkg::MUL_W'(nl_d_ff); mb = tpms_pkg::MUL_W'(sine); end
         default: begin end
      endcase
   end

   assign prod_acc = tpms_pkg::ACC_W'(prod_ff);
   assign lin_res  = round_sat(acc_lin_ff);
   assign nl_res   = round_sat(acc_nl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_a_ff       <= 16'sd12288;
         lin_b_ff       <= 16'sd2949;
         nl_a_ff        <= 16'sd12288;
         nl_b_ff        <= 16'sd2949;
         nl_c_ff        <= 16'sd1147;
         nl_d_ff        <= 16'sd1966;
         y_lin_last_ff  <= '0;
         y_nl_last_ff   <= '0;
         y_nl_before_ff <= '0;
         u_last_ff      <= '0;
         first_done_ff  <= 1'b0;
         op_ff          <= tpms_pkg::OP_NOP;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tpms_pkg::REG_LIN_A: lin_a_ff <= csr_data;
               tpms_pkg::REG_LIN_B: lin_b_ff <= csr_data;
               tpms_pkg::REG_NL_A:  nl_a_ff  <= csr_data;
               tpms_pkg::REG_NL_B:  nl_b_ff  <= csr_data;
               tpms_pkg::REG_NL_C:  nl_c_ff  <= csr_data;
               tpms_pkg::REG_NL_D:  nl_d_ff  <= csr_data;
               default: begin end
            endcase
         end
         op_ff <= cmd.op;
         if (cmd.load && restart) begin
            y_lin_last_ff  <= '0;
            y_nl_last_ff   <= '0;
            y_nl_before_ff <= '0;
            u_last_ff      <= '0;
            first_done_ff  <= 1'b0;
         end else if (cmd.finish) begin
            y_lin_last_ff  <= lin_res[tpms_pkg::SAMPLE_W-1:0];
            y_nl_before_ff <= y_nl_last_ff;
            y_nl_last_ff   <= nl_res[tpms_pkg::SAMPLE_W-1:0];
            u_last_ff      <= u_ff;
            first_done_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= ma * mb;
      if (cmd.load) begin
         u_ff       <= u_in;
         acc_lin_ff <= '0;
         acc_nl_ff  <= '0;
      end else begin
         case (op_ff)
            tpms_pkg::OP_LA, tpms_pkg::OP_LB: acc_lin_ff <= acc_lin_ff + prod_acc;
            tpms_pkg::OP_NA, tpms_pkg::OP_NC, tpms_pkg::OP_ND: acc_nl_ff <= acc_nl_ff + prod_acc;
            tpms_pkg::OP_SQ: sq_ff <= prod_ff[tpms_pkg::SQ_W+15:16];
            tpms_pkg::OP_BL: acc_nl_ff <= acc_nl_ff - prod_acc;
            tpms_pkg::OP_BH: acc_nl_ff <= acc_nl_ff - (prod_acc <<< 24);
            default: begin end
         endcase
      end
      if (cmd.finish) begin
         y_lin_out_ff <= lin_res[tpms_pkg::SAMPLE_W-1:0];
         y_nl_out_ff  <= nl_res[tpms_pkg::SAMPLE_W-1:0];
         sat_out_ff   <= lin_res[tpms_pkg::SAMPLE_W] | nl_res[tpms_pkg::SAMPLE_W];
      end
   end

   assign status.first_done = first_done_ff;
   assign status.sine_done  = sine_done;
   assign y_linear          = y_lin_out_ff;
   assign y_nonlinear       = y_nl_out_ff;
   assign saturated         = sat_out_ff;

endmodule

// ----- hdl/tpms_ctrl.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: controller
// Sequences the multiply-accumulate steps, waits for the sine and owns the
// handshakes.
// ----------------------------------------------------------------------------
`include "thermal_plant_model_step_macros.svh"

module tpms_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tpms_pkg::status_type status,
   output tpms_pkg::cmd_type    cmd
);

   tpms_pkg::ctrl_state_type state_ff, state_in;
   logic [3:0]               step_ff, step_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   tpms_pkg::mac_op_type     step_op;
   logic                     out_free;

   always_comb begin
      case (step_ff)
         4'd0:    step_op = tpms_pkg::OP_LA;
         4'd1:    step_op = tpms_pkg::OP_LB;
         4'd2:    step_op = tpms_pkg::OP_NA;
         4'd3:    step_op = tpms_pkg::OP_NC;
         4'd4:    step_op = tpms_pkg::OP_SQ;
         4'd6:    step_op = tpms_pkg::OP_BL;
         4'd7:    step_op = tpms_pkg::OP_BH;
         4'd8:    step_op = tpms_pkg::OP_ND;
         default: step_op = tpms_pkg::OP_NOP;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         tpms_pkg::CT_IDLE: begin
            if (req_valid) begin
               state_in = tpms_pkg::CT_RUN;
               step_in  = '0;
            end
         end
         tpms_pkg::CT_RUN: begin
            if (step_ff == tpms_pkg::STEP_NC && !status.first_done) begin
               state_in = tpms_pkg::CT_DRAIN;
            end else if (step_ff == tpms_pkg::STEP_ND) begin
               if (status.sine_done) begin
                  state_in = tpms_pkg::CT_DRAIN;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         tpms_pkg::CT_DRAIN: state_in = tpms_pkg::CT_FINISH;
         tpms_pkg::CT_FINISH: begin
            if (out_free) begin
               state_in = tpms_pkg::CT_IDLE;
            end
         end
         default: state_in = tpms_pkg::CT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.load       = 1'b0;
      cmd.sine_start = 1'b0;
      cmd.op         = tpms_pkg::OP_NOP;
      cmd.finish     = 1'b0;
      req_ready      = 1'b0;
      case (state_ff)
         tpms_pkg::CT_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         tpms_pkg::CT_RUN: begin
            cmd.sine_start = (step_ff == 4'd0);
            // hold the sine term until the unit is done
            if (!(step_ff == tpms_pkg::STEP_ND && !status.sine_done)) begin
               cmd.op = step_op;
            end
         end
         tpms_pkg::CT_FINISH: cmd.finish = out_free;
         default: begin end
      endcase
   end

   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tpms_pkg::CT_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `TPMS_ASSERT_IMP(a_finish_free, clock, reset, cmd.finish, !rsp_valid_ff || rsp_ready)
   `TPMS_ASSERT_IMP(a_sine_ready, clock, reset, cmd.op == tpms_pkg::OP_ND, status.sine_done)
   `TPMS_ASSERT_NEXT(a_load_runs, clock, reset, cmd.load, state_ff == tpms_pkg::CT_RUN && step_ff == 4'd0)

endmodule

// ----- hdl/thermal_plant_model_step.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: top level
// Advances a linear and a nonlinear thermal plant model by one tick per
// request beat and returns both saturated Q16.16 outputs in one response beat.
// ----------------------------------------------------------------------------
// One sample is processed at a time. The time from request to response is
// set by the sine unit: range reduction, a fold, the CORDIC iterations and a
// rounding step; the multiply-accumulate steps on the single shared
// multiplier run alongside it. A first tick, after reset or a restart, skips
// the sine and square terms. A new request is taken once the previous result
// has entered the response register.
module thermal_plant_model_step #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   tpms_req_if.sink                       req_ch,
   tpms_rsp_if.source                     rsp_ch,
   input  logic                           csr_we,
   input  logic [tpms_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tpms_pkg::COEF_W-1:0]    csr_data
);

   tpms_pkg::cmd_type    cmd;
   tpms_pkg::status_type status;

   tpms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tpms_datapath #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .u_in        (req_ch.u_in),
      .restart     (req_ch.restart),
      .y_linear    (rsp_ch.y_linear),
      .y_nonlinear (rsp_ch.y_nonlinear),
      .saturated   (rsp_ch.saturated)
   );

endmodule

// ----- tb/thermal_plant_model_step_tb.sv -----
// ----------------------------------------------------------------------------
// Thermal plant model step: testbench
// Drives control samples over the request channel, predicts both plant model
// outputs with a bit-exact fixed-point model of the step, and checks every
// response beat in order. Coefficients are rewritten between phases.
// ----------------------------------------------------------------------------
module thermal_plant_model_step_tb;

   typedef struct packed {
      logic signed [31:0] y_lin;
      logic signed [31:0] y_nl;
      logic               clip;
   } plant_out_type;

   localparam int CORDIC_STEPS = 16;
   localparam longint LIMIT = 2000000;
   localparam logic [tpms_pkg::CSR_IDX_W-1:0] NO_REG_INDEX = 3'd6;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [tpms_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [tpms_pkg::COEF_W-1:0] csr_data = '0;

   tpms_req_if req_ch();
   tpms_rsp_if rsp_ch();

   thermal_plant_model_step #(.CORDIC_ITERATIONS(CORDIC_STEPS)) i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic signed [15:0] coef [6];
   logic signed [31:0] lin_prev, nl_prev, nl_prev2, u_prev;
   logic               warm;

   plant_out_type expected_q[$];
   int  mismatches = 0;
   int  hold_off = 0;
   int  stall_req = 0;
   longint cycle = 0;

   initial forever #10 clock = ~clock;

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > LIMIT) begin
         $display("thermal_plant_model_step_tb: FAIL");
         $finish;
      end
   end

   function automatic longint floor_shr(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint sine_of(logic signed [31:0] ang);
      longint r, x, y, z, dx, dy;
      r = (longint'(ang) * 16384) % longint'(tpms_pkg::ANG_TWO_PI);
      if (r < 0) r += longint'(tpms_pkg::ANG_TWO_PI);
      if (r > longint'(tpms_pkg::ANG_PI)) r -= longint'(tpms_pkg::ANG_TWO_PI);
      if (r > longint'(tpms_pkg::ANG_HALF_PI)) r = longint'(tpms_pkg::ANG_PI) - r;
      else if (r < -longint'(tpms_pkg::ANG_HALF_PI)) r = -longint'(tpms_pkg::ANG_PI) - r;
      x = longint'(tpms_pkg::GAIN_INV);
      y = 0;
      z = r;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(tpms_pkg::atan_at(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(tpms_pkg::atan_at(5'(i)));
         end
      end
      return floor_shr(y + 32768, 16);
   endfunction

   function automatic logic signed [31:0] round_sat(longint acc, ref logic clip);
      longint r;
      r = floor_shr(acc + 8192, 14);
      if (r > 64'sd2147483647) begin
         clip = 1; return 32'sh7fffffff;
      end
      if (r < -64'sd2147483648) begin
         clip = 1; return 32'sh80000000;
      end
      return r[31:0];
   endfunction

   function automatic plant_out_type advance_plant(logic signed [31:0] u, logic restart);
      plant_out_type o;
      longint acc, sq;
      logic clip;
      clip = 0;
      if (restart) begin
         lin_prev = 0; nl_prev = 0; nl_prev2 = 0; u_prev = 0; warm = 0;
      end
      acc = longint'(coef[tpms_pkg::REG_LIN_A]) * lin_prev
            + longint'(coef[tpms_pkg::REG_LIN_B]) * u;
      o.y_lin = round_sat(acc, clip);
      acc = longint'(coef[tpms_pkg::REG_NL_A]) * nl_prev
            + longint'(coef[tpms_pkg::REG_NL_C]) * u;
      if (warm) begin
         sq = floor_shr(longint'(nl_prev2) * nl_prev2, 16);
         acc -= longint'(coef[tpms_pkg::REG_NL_B]) * sq;
         acc += longint'(coef[tpms_pkg::REG_NL_D]) * sine_of(u_prev);
      end
      o.y_nl = round_sat(acc, clip);
      o.clip = clip;
      lin_prev = o.y_lin;
      nl_prev2 = nl_prev;
      nl_prev = o.y_nl;
      u_prev = u;
      warm = 1;
      return o;
   endfunction

   // result checker
   always @(posedge clock) begin
      plant_out_type got, exp_o;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.y_linear, rsp_ch.y_nonlinear, rsp_ch.saturated};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %p", got);
         end else begin
            exp_o = expected_q.pop_front();
            if (got !== exp_o) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
                           exp_o.y_lin, exp_o.y_nl, exp_o.clip,
                           got.y_lin, got.y_nl, got.clip);
            end
         end
      end
   end

   // receiver: short random refusals, occasional long holds
   always @(posedge clock) begin
      if (stall_req > 0) begin
         hold_off <= stall_req;
         stall_req = 0;
         rsp_ch.ready <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ch.ready <= 0;
      end else if ($urandom_range(99) < 8) rsp_ch.ready <= 0;
      else if ($urandom_range(99) < 2) begin
         hold_off <= $urandom_range(300, 60);
         rsp_ch.ready <= 0;
      end else rsp_ch.ready <= 1;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.u_in = '0;
      req_ch.restart = 0;
      rsp_ch.ready = 0;
   end

   task automatic send_sample(logic signed [31:0] u, logic restart, bit gaps = 1);
      int g;
      if (gaps) begin
         g = ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(2);
         if ($urandom_range(3) == 0) g = 0;
         if (g > 0) begin
            req_ch.valid <= 0;
            repeat (g) @(posedge clock);
         end
      end
      req_ch.valid <= 1;
      req_ch.u_in <= u;
      req_ch.restart <= restart;
      expected_q.push_back(advance_plant(u, restart));
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_coef(logic [tpms_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val,
                             bit keep_we = 0);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= val;
      // indexes past the last register are dropped by the block
      if (idx <= tpms_pkg::REG_NL_D) coef[idx] = val;
      @(posedge clock);
      if (!keep_we) csr_we <= 0;
   endtask

   task automatic load_coefs(logic [15:0] la, lb, na, nb, nc, nd);
      write_coef(tpms_pkg::REG_LIN_A, la, 1);
      write_coef(tpms_pkg::REG_LIN_B, lb, 1);
      write_coef(tpms_pkg::REG_NL_A, na, 1);
      write_coef(tpms_pkg::REG_NL_B, nb, 1);
      write_coef(tpms_pkg::REG_NL_C, nc, 1);
      write_coef(tpms_pkg::REG_NL_D, nd);
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'($signed($urandom_range(400000)) - 200000);
         2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                     : 32'h80000000 + $urandom_range(3);
         default: return 32'($signed($urandom_range(2000000)) - 1000000);
      endcase
   endfunction

   function automatic logic [15:0] rand_coef();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(1) ? 16'h7fff : 16'h8000;
         default: return 16'($urandom_range(16384));
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] vals [12] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000,
                                 32'hffff0000, 32'h0003243f, 32'hfffcdbc1,
                                 32'h00019220, 32'h7fffffff, 32'h80000000,
                                 32'hffffffff, 32'h00000001};
      foreach (vals[i]) send_sample(vals[i], i == 6 || i == 9);
      send_sample(32'h00050000, 1);
      send_sample(32'h00050000, 0);
      send_sample(32'h00050000, 0);
      drain_results();
   endtask

   task automatic test_extreme_coefs();
      load_coefs(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
      for (int i = 0; i < 6; i++) send_sample(i[0] ? 32'h7fffffff : 32'h80000000, i == 0);
      drain_results();
      load_coefs(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
      for (int i = 0; i < 6; i++) send_sample(rand_sample(), i == 0);
      drain_results();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) begin
            drain_results();
            if (i % 300 == 0) load_coefs(16'd12288, 16'd2949, 16'd12288, 16'd2949,
                                         16'd1147, 16'd1966);
            else load_coefs(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                            rand_coef(), rand_coef());
         end
         send_sample(rand_sample(), $urandom_range(19) == 0);
      end
      drain_results();
   endtask

   task automatic test_back_pressure();
      // hold the response side while samples keep coming
      stall_req = 400;
      for (int i = 0; i < 12; i++) send_sample(rand_sample(), 0, 0);
      drain_results();
   endtask

   task automatic test_bad_index();
      write_coef(NO_REG_INDEX, 16'hffff);
      send_sample(32'h00020000, 1);
      drain_results();
   endtask

   initial begin
      coef = '{16'sd12288, 16'sd2949, 16'sd12288, 16'sd2949, 16'sd1147, 16'sd1966};
      lin_prev = 0; nl_prev = 0; nl_prev2 = 0; u_prev = 0; warm = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_extreme_coefs();
      test_back_pressure();
      test_random(1000);
      test_bad_index();
      if (mismatches == 0) $display("thermal_plant_model_step_tb: PASS");
      else $display("thermal_plant_model_step_tb: FAIL");
      $finish;
   end

endmodule
